@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, off while rst_n is low.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tmn_pkg.sv @@
`default_nettype none

package tmn_pkg;

    localparam int ID_W             = 8;
    localparam int OP_W             = 2;
    localparam int KIND_W           = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int CMD_DEPTH        = 2;
    localparam int OUT_DEPTH        = 4;

    typedef enum logic [OP_W-1:0] {
        OP_WISH    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_TOKEN   = 2'd2,
        OP_EXIT    = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TOKEN    = 2'd0,
        KIND_REQUEST  = 2'd1,
        KIND_ENTER    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ID        = 2'd0,
        REG_INITIAL_HOLDER = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EV_PUSH  = 2'd0,
        EV_TOKEN = 2'd1,
        EV_EXIT  = 2'd2
    } ev_kind_t;

    typedef enum logic {
        BK_FETCH   = 1'b0,
        BK_RESOLVE = 1'b1
    } bk_state_t;

    typedef struct packed {
        ev_kind_t        kind;
        logic [ID_W-1:0] who;
    } ev_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] dest;
        logic            last;
    } res_t;

endpackage

`default_nettype wire

@@ src/tmn_front.sv @@
`default_nettype none

module tmn_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [tmn_pkg::ID_W-1:0]   s_axis_tdata,
    input  wire logic [tmn_pkg::OP_W-1:0]   s_axis_tuser,
    input  wire logic [tmn_pkg::ID_W-1:0]   node_id,
    output logic                            ev_valid,
    input  wire logic                       ev_ready,
    output tmn_pkg::ev_t                    ev
);
    import tmn_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    ev_t              q_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ev_t              ev_in;
    logic             push, pop;

    always_comb
    begin
        ev_in.who = s_axis_tdata;
        case (op_t'(s_axis_tuser))
            OP_WISH:
            begin
                ev_in.kind = EV_PUSH;
                ev_in.who  = node_id;
            end
            OP_REQUEST: ev_in.kind = EV_PUSH;
            OP_TOKEN:   ev_in.kind = EV_TOKEN;
            OP_EXIT:    ev_in.kind = EV_EXIT;
            default:    ev_in.kind = EV_EXIT;
        endcase
    end

    assign s_axis_tready = (cnt_reg != CNT_W'(CMD_DEPTH));
    assign ev_valid      = (cnt_reg != '0);
    assign ev            = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = ev_valid && ev_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= ev_in;
        end
    end

endmodule

`default_nettype wire

@@ src/tmn_back.sv @@
`default_nettype none

module tmn_back #(
    parameter int QUEUE_DEPTH = tmn_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [tmn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tmn_pkg::ID_W-1:0]       cfg_data,
    output logic [tmn_pkg::ID_W-1:0]            node_id,
    input  wire logic                           ev_valid,
    output logic                                ev_ready,
    input  wire tmn_pkg::ev_t                   ev,
    input  wire logic                           room2,
    output logic [1:0]                          res_v,
    output tmn_pkg::res_t                       res0,
    output tmn_pkg::res_t                       res1
);
    import tmn_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    bk_state_t        state_reg, state_next;
    logic [ID_W-1:0]  node_id_reg, node_id_next;
    logic [ID_W-1:0]  holder_reg, holder_next;
    logic             in_use_reg, in_use_next;
    logic             asked_reg, asked_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [ID_W-1:0]  ovf_id_reg, ovf_id_next;

    logic [ID_W-1:0]  req_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]  rd_reg;
    logic [ID_W-1:0]  wd_reg;
    logic             byp_reg;

    logic             fetch;
    logic             mem_we;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] tail_wrap;
    logic [PTR_W-1:0] wr_addr;
    logic [ID_W-1:0]  head_val;
    logic             priv;
    logic             req;
    logic [ID_W-1:0]  holder_p;
    logic [CNT_W-1:0] count_p;

    assign node_id  = node_id_reg;
    assign fetch    = (state_reg == BK_FETCH) && ev_valid && room2;
    assign ev_ready = fetch;

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                        : tail_sum;
    assign wr_addr   = tail_wrap[PTR_W-1:0];
    assign mem_we    = fetch && (ev.kind == EV_PUSH) && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_val  = byp_reg ? wd_reg : rd_reg;

    // privilege then request, on state left by the fetch cycle
    assign priv     = (holder_reg == node_id_reg) && !in_use_reg && (count_reg != '0);
    assign holder_p = priv ? head_val : holder_reg;
    assign count_p  = priv ? count_reg - 1'b1 : count_reg;
    assign req      = (holder_p != node_id_reg) && (count_p != '0) && (priv || !asked_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_FETCH:
            begin
                if (fetch)
                begin
                    state_next = BK_RESOLVE;
                end
            end
            BK_RESOLVE: state_next = BK_FETCH;
            default:    state_next = BK_FETCH;
        endcase
    end

    always_comb
    begin
        node_id_next = node_id_reg;
        holder_next  = holder_reg;
        in_use_next  = in_use_reg;
        asked_next   = asked_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        ovf_id_next  = ovf_id_reg;
        res_v        = 2'b00;
        res0         = '{kind: KIND_TOKEN, dest: holder_p, last: 1'b1};
        res1         = '{kind: KIND_REQUEST, dest: holder_p, last: 1'b1};

        case (state_reg)
            BK_FETCH:
            begin
                if (fetch)
                begin
                    ovf_next    = 1'b0;
                    ovf_id_next = ev.who;
                    case (ev.kind)
                        EV_PUSH:
                        begin
                            if (mem_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        EV_TOKEN: holder_next = node_id_reg;
                        EV_EXIT:  in_use_next = 1'b0;
                        default:  in_use_next = in_use_reg;
                    endcase
                end
            end
            BK_RESOLVE:
            begin
                if (ovf_reg)
                begin
                    res_v = 2'b01;
                    res0  = '{kind: KIND_OVERFLOW, dest: ovf_id_reg, last: 1'b1};
                end
                else
                begin
                    holder_next = holder_p;
                    count_next  = count_p;
                    if (priv)
                    begin
                        head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
                        asked_next = 1'b0;
                        res_v      = req ? 2'b11 : 2'b01;
                        res0.last  = !req;
                        if (head_val == node_id_reg)
                        begin
                            in_use_next = 1'b1;
                            res0.kind   = KIND_ENTER;
                            res0.dest   = node_id_reg;
                        end
                    end
                    else if (req)
                    begin
                        res_v     = 2'b01;
                        res0.kind = KIND_REQUEST;
                    end
                    if (req)
                    begin
                        asked_next = 1'b1;
                    end
                end
            end
            default:
            begin
                res_v = 2'b00;
            end
        endcase

        if (cfg_valid)
        begin
            if (cfg_index == REG_NODE_ID)
            begin
                node_id_next = cfg_data;
            end
            else if (cfg_index == REG_INITIAL_HOLDER)
            begin
                holder_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_FETCH;
            node_id_reg <= '0;
            holder_reg  <= '0;
            in_use_reg  <= 1'b0;
            asked_reg   <= 1'b0;
            head_reg    <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            node_id_reg <= node_id_next;
            holder_reg  <= holder_next;
            in_use_reg  <= in_use_next;
            asked_reg   <= asked_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
        end
    end

    // queue store; a push to the head address is forwarded
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            req_mem[wr_addr] <= ev.who;
        end
        rd_reg     <= req_mem[head_reg];
        wd_reg     <= ev.who;
        byp_reg    <= mem_we && (wr_addr == head_reg);
        ovf_id_reg <= ovf_id_next;
    end

endmodule

`default_nettype wire

@@ src/tmn_out_buf.sv @@
`default_nettype none

module tmn_out_buf (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 res_v,
    input  wire tmn_pkg::res_t              res0,
    input  wire tmn_pkg::res_t              res1,
    output logic                            room2,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [tmn_pkg::ID_W-1:0]        m_axis_tdata,
    output logic [tmn_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import tmn_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    res_t             q_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_ptr_1;
    logic [CNT_W-1:0] n_in;
    logic             pop;
    res_t             head;

    assign head          = q_reg[rd_ptr_reg];
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = head.dest;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign room2         = (cnt_reg <= CNT_W'(OUT_DEPTH - 2));
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign wr_ptr_1      = wr_ptr_reg + 1'b1;
    assign n_in          = CNT_W'(res_v[0]) + CNT_W'(res_v[1]);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_in);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + n_in - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_v[0])
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (res_v[1])
        begin
            q_reg[wr_ptr_1] <= res1;
        end
    end

endmodule

`default_nettype wire

@@ src/token_tree_mutex_node_top.sv @@
// Channel   | Dir | Handshake               | Item
// s_axis    | in  | s_axis_tvalid / tready  | event: tuser opcode, tdata sender_id
// m_axis    | out | m_axis_tvalid / tready  | message: tuser kind, tdata dest_id, tlast
// cfg       | in  | cfg_valid / cfg_ready   | cfg_index register, cfg_data value
//
// The executing stage handles each event in a fetch state (state update with
// queue read), then a resolve state (grant and request), so it takes no new
// event until the last one is resolved; a two-entry event queue and a
// four-entry result queue decouple the ports. Each event gives zero, one or two messages, the last one tagged.
// Reset clears all control state; the request queue needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module token_tree_mutex_node_top #(
    parameter int QUEUE_DEPTH = tmn_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [tmn_pkg::ID_W-1:0]       s_axis_tdata,   // sender_id
    input  wire logic [tmn_pkg::OP_W-1:0]       s_axis_tuser,   // opcode
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [tmn_pkg::ID_W-1:0]            m_axis_tdata,   // dest_id
    output logic [tmn_pkg::KIND_W-1:0]          m_axis_tuser,   // kind
    output logic                                m_axis_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tmn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tmn_pkg::ID_W-1:0]       cfg_data
);
    import tmn_pkg::*;

    logic            ev_valid;
    logic            ev_ready;
    ev_t             ev;
    logic [ID_W-1:0] node_id;
    logic            room2;
    logic [1:0]      res_v;
    res_t            res0;
    res_t            res1;

    assign cfg_ready = 1'b1;

    tmn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .node_id       (node_id),
        .ev_valid      (ev_valid),
        .ev_ready      (ev_ready),
        .ev            (ev)
    );

    tmn_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .node_id   (node_id),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev        (ev),
        .room2     (room2),
        .res_v     (res_v),
        .res0      (res0),
        .res1      (res1)
    );

    tmn_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_v         (res_v),
        .res0          (res0),
        .res1          (res1),
        .room2         (room2),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `ASSERT_CLK(a_second_needs_first, res_v[1] |-> res_v[0], "second result without first")
    `ASSERT_CLK(a_overflow_alone, (res_v[0] && res0.kind == KIND_OVERFLOW) |-> (res0.last && !res_v[1]), "overflow not alone")
    `ASSERT_CLK(a_fetch_spacing, (ev_valid && ev_ready) |=> !ev_ready, "back took two events in a row")
    `ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !m_axis_tvalid, "result shown in reset")

endmodule

`default_nettype wire

@@ dv/token_tree_mutex_node_checker.sv @@
`timescale 1ns / 100ps

module token_tree_mutex_node_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [tmn_pkg::ID_W-1:0]      s_axis_tdata,
    input  wire logic [tmn_pkg::OP_W-1:0]      s_axis_tuser,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [tmn_pkg::ID_W-1:0]      m_axis_tdata,
    input  wire logic [tmn_pkg::KIND_W-1:0]    m_axis_tuser,
    input  wire logic                          m_axis_tlast,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [tmn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tmn_pkg::ID_W-1:0]      cfg_data,
    output int                                 mismatches,
    output int                                 msgs_due
);
    import tmn_pkg::*;

    localparam int QDEPTH    = QUEUE_DEPTH_DEF;
    localparam int SHOWN_MAX = 10;

    logic [ID_W-1:0] my_id;
    logic [ID_W-1:0] toward;
    logic            in_cs;
    logic            req_out;
    logic [ID_W-1:0] waiters [QDEPTH];
    int              w_head;
    int              w_len;
    res_t            due_q [$];

    // node state update, privilege grant, then request towards the token
    task automatic take_event(input op_t op, input logic [ID_W-1:0] sender);
        res_t            msg [2];
        int              n;
        logic [ID_W-1:0] who;
        n = 0;
        if (op == OP_WISH || op == OP_REQUEST)
        begin
            who = (op == OP_WISH) ? my_id : sender;
            if (w_len >= QDEPTH)
            begin
                due_q.push_back('{KIND_OVERFLOW, who, 1'b1});
                return;
            end
            waiters[(w_head + w_len) % QDEPTH] = who;
            w_len++;
        end
        else if (op == OP_TOKEN)
            toward = my_id;
        else
            in_cs = 1'b0;

        if (toward == my_id && !in_cs && w_len > 0)
        begin
            toward  = waiters[w_head];
            w_head  = (w_head + 1) % QDEPTH;
            w_len--;
            req_out = 1'b0;
            if (toward == my_id)
            begin
                in_cs  = 1'b1;
                msg[n] = '{KIND_ENTER, my_id, 1'b0};
            end
            else
                msg[n] = '{KIND_TOKEN, toward, 1'b0};
            n++;
        end

        if (toward != my_id && w_len > 0 && !req_out)
        begin
            req_out = 1'b1;
            msg[n]  = '{KIND_REQUEST, toward, 1'b0};
            n++;
        end

        if (n > 0)
            msg[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            due_q.push_back(msg[i]);
    endtask

    task automatic note_mismatch(input string what, input res_t want, input res_t got);
        if (mismatches < SHOWN_MAX)
            $display("%0t: %s: expected kind %0d dest %0d last %0d, got kind %0d dest %0d last %0d",
                     $realtime, what, want.kind, want.dest, want.last,
                     got.kind, got.dest, got.last);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            my_id      = '0;
            toward     = '0;
            in_cs      = 1'b0;
            req_out    = 1'b0;
            w_head     = 0;
            w_len      = 0;
            due_q.delete();
            mismatches = 0;
            msgs_due   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{kind_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast};
                if (due_q.size() == 0)
                    note_mismatch("unexpected message", '0, got);
                else
                begin
                    want = due_q.pop_front();
                    if (got.kind !== want.kind || got.dest !== want.dest
                        || got.last !== want.last)
                        note_mismatch("message mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NODE_ID:        my_id  = cfg_data;
                    REG_INITIAL_HOLDER: toward = cfg_data;
                    default:            ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_event(op_t'(s_axis_tuser), s_axis_tdata);
            msgs_due = due_q.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import tmn_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_EVENTS  = 108;
    localparam int ID_MAX        = (1 << ID_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [ID_W-1:0]      s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [ID_W-1:0]      cfg_data      = '0;
    wire logic            s_axis_tready;
    wire logic            m_axis_tvalid;
    wire logic [ID_W-1:0] m_axis_tdata;
    wire logic [KIND_W-1:0] m_axis_tuser;
    wire logic            m_axis_tlast;
    wire logic            cfg_ready;

    int              src_idle_pct   = 0;
    int              sink_stall_pct = 0;
    int              mismatches;
    int              msgs_due;
    logic [ID_W-1:0] nbr [3];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    token_tree_mutex_node_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    token_tree_mutex_node_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .msgs_due      (msgs_due)
    );

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // valid is left high after the item; the next call or stop_events decides
    task automatic send_event(input op_t op, input logic [ID_W-1:0] sid);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= sid;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic stop_events();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (msgs_due != 0);
        @(posedge clk);
    endtask

    task automatic random_event(input int push_pct, input logic [ID_W-1:0] self_id);
        int              r;
        op_t             op;
        logic [ID_W-1:0] sid;
        r = $urandom_range(99);
        if (r < push_pct)
            op = ($urandom_range(3) == 0) ? OP_WISH : OP_REQUEST;
        else
            op = ($urandom_range(1) == 0) ? OP_TOKEN : OP_EXIT;
        r = $urandom_range(99);
        if (r < 60)
            sid = nbr[$urandom_range(2)];
        else if (r < 75)
            sid = self_id;
        else
            sid = ID_W'($urandom_range(ID_MAX));
        send_event(op, sid);
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[token_tree_mutex_node_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [ID_W-1:0] id_now;
        logic [ID_W-1:0] hold_now;
        int              push_pct;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // token starts here; spare register indexes must have no effect
        write_reg(REG_NODE_ID, 8'd5);
        write_reg(REG_INITIAL_HOLDER, 8'd5);
        write_reg(CFG_IDX_SPARE_LO, 8'hFF);
        write_reg(CFG_IDX_SPARE_HI, 8'h00);

        send_event(OP_WISH, 8'h00);
        send_event(OP_REQUEST, 8'h00);
        send_event(OP_REQUEST, 8'hFF);
        send_event(OP_EXIT, 8'h00);
        send_event(OP_REQUEST, 8'd5);
        send_event(OP_WISH, 8'hFF);
        send_event(OP_TOKEN, 8'h00);
        send_event(OP_TOKEN, 8'h00);
        send_event(OP_TOKEN, 8'hFF);
        send_event(OP_EXIT, 8'h00);
        send_event(OP_EXIT, 8'hFF);
        send_event(OP_EXIT, 8'h00);
        send_event(OP_REQUEST, 8'h01);
        for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
            send_event(OP_REQUEST, 8'hA0 + i[ID_W-1:0]);
        send_event(OP_REQUEST, 8'h80);
        send_event(OP_WISH, 8'h00);
        send_event(OP_TOKEN, 8'h00);
        stop_events();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    src_idle_pct   <= 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    src_idle_pct   <= 47;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    src_idle_pct   <= 0;
                    sink_stall_pct <= 47;
                end
                default:
                begin
                    src_idle_pct   <= 24;
                    sink_stall_pct <= 24;
                end
            endcase

            case (ph)
                0:
                begin
                    id_now   = '0;
                    hold_now = '0;
                end
                1:
                begin
                    id_now   = ID_W'(ID_MAX);
                    hold_now = ID_W'(ID_MAX);
                end
                2:
                begin
                    id_now   = '0;
                    hold_now = ID_W'(ID_MAX);
                end
                3:
                begin
                    id_now   = ID_W'(ID_MAX);
                    hold_now = '0;
                end
                default:
                begin
                    id_now   = ID_W'($urandom_range(ID_MAX));
                    hold_now = ($urandom_range(1) == 0) ? id_now
                                                        : ID_W'($urandom_range(ID_MAX));
                end
            endcase

            if (ph % 2 == 0)
            begin
                write_reg(REG_NODE_ID, id_now);
                write_reg(REG_INITIAL_HOLDER, hold_now);
            end
            else
            begin
                write_reg(REG_INITIAL_HOLDER, hold_now);
                write_reg(REG_NODE_ID, id_now);
            end

            for (int k = 0; k < 3; k++)
                nbr[k] = ID_W'($urandom_range(ID_MAX));
            nbr[0]   = hold_now;
            push_pct = 40 + 5 * ph;

            for (int e = 0; e < PHASE_EVENTS; e++)
            begin
                if (e == PHASE_EVENTS / 2)
                begin
                    stop_events();
                    wait_drained();
                end
                random_event(push_pct, id_now);
            end
            stop_events();
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        @(negedge clk);
        if (mismatches == 0 && msgs_due == 0)
            $display("[token_tree_mutex_node_top] OK");
        else
            $display("[token_tree_mutex_node_top] ERROR");
        $finish;
    end

endmodule
